### hdl/mrta_pkg.sv
`default_nettype none

package mrta_pkg;

  localparam int NFIELDS         = 7;
  localparam int FIELD_WIDTH_DEF = 16;
  localparam int OPW             = 16;
  localparam int RADW            = OPW + 1;
  localparam int PRODW           = OPW + RADW;
  localparam int FUNC_W          = 3;
  localparam int FLD_W           = 3;
  localparam int CFG_IDX_W       = 3;

  typedef logic [OPW-1:0]    word_t;
  typedef logic [FLD_W-1:0]  fld_t;
  typedef logic [FUNC_W-1:0] func_code_t;

  localparam fld_t FLD_YEAR   = 3'd0;
  localparam fld_t FLD_MONTH  = 3'd1;
  localparam fld_t FLD_DAY    = 3'd2;
  localparam fld_t FLD_HOUR   = 3'd3;
  localparam fld_t FLD_MINUTE = 3'd4;
  localparam fld_t FLD_SECOND = 3'd5;
  localparam fld_t FLD_MILLI  = 3'd6;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 3'd0,
    FN_ADD   = 3'd1,
    FN_SUB   = 3'd2,
    FN_CMP   = 3'd3,
    FN_DIV   = 3'd4,
    FN_CLEAR = 3'd5
  } func_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MILLI_LIMIT  = 3'd0;
  localparam cfg_idx_t CFG_SECOND_LIMIT = 3'd1;
  localparam cfg_idx_t CFG_MINUTE_LIMIT = 3'd2;
  localparam cfg_idx_t CFG_HOUR_LIMIT   = 3'd3;
  localparam cfg_idx_t CFG_DAY_LIMIT    = 3'd4;
  localparam cfg_idx_t CFG_MONTH_LIMIT  = 3'd5;
  localparam cfg_idx_t CFG_YEAR_LIMIT   = 3'd6;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

  localparam word_t LIM_RST [NFIELDS] = '{
    16'd4095, 16'd11, 16'd30, 16'd23, 16'd59, 16'd59, 16'd999
  };

  function automatic fld_t cfg_field(input cfg_idx_t idx);
    fld_t f;
    unique case (idx)
      CFG_MILLI_LIMIT:  f = FLD_MILLI;
      CFG_SECOND_LIMIT: f = FLD_SECOND;
      CFG_MINUTE_LIMIT: f = FLD_MINUTE;
      CFG_HOUR_LIMIT:   f = FLD_HOUR;
      CFG_DAY_LIMIT:    f = FLD_DAY;
      CFG_MONTH_LIMIT:  f = FLD_MONTH;
      default:          f = FLD_YEAR;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

### hdl/mrta_if.sv
`default_nettype none

interface mrta_in_if;
  logic                       valid;
  logic                       ready;
  logic [mrta_pkg::FUNC_W-1:0] func;
  mrta_pkg::word_t            op_year;
  mrta_pkg::word_t            op_month;
  mrta_pkg::word_t            op_day;
  mrta_pkg::word_t            op_hour;
  mrta_pkg::word_t            op_minute;
  mrta_pkg::word_t            op_second;
  mrta_pkg::word_t            op_milli;
  mrta_pkg::word_t            divisor;

  modport source (
    output valid, func, op_year, op_month, op_day, op_hour, op_minute, op_second,
           op_milli, divisor,
    input  ready
  );
  modport sink (
    input  valid, func, op_year, op_month, op_day, op_hour, op_minute, op_second,
           op_milli, divisor,
    output ready
  );
endinterface

interface mrta_out_if;
  logic            valid;
  logic            ready;
  mrta_pkg::word_t res_year;
  mrta_pkg::word_t res_month;
  mrta_pkg::word_t res_day;
  mrta_pkg::word_t res_hour;
  mrta_pkg::word_t res_minute;
  mrta_pkg::word_t res_second;
  mrta_pkg::word_t res_milli;
  logic [1:0]      order;
  logic [1:0]      status;
  logic            out_of_range;
  logic            is_empty;

  modport source (
    output valid, res_year, res_month, res_day, res_hour, res_minute, res_second,
           res_milli, order, status, out_of_range, is_empty,
    input  ready
  );
  modport sink (
    input  valid, res_year, res_month, res_day, res_hour, res_minute, res_second,
           res_milli, order, status, out_of_range, is_empty,
    output ready
  );
endinterface

`default_nettype wire

### hdl/mrta_div.sv
`default_nettype none

module mrta_div #(
  parameter int DW = 33
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire [DW-1:0]                  dividend,
  input  wire [mrta_pkg::RADW-1:0]      divisor,
  output logic                          done,
  output logic [DW-1:0]                 quot,
  output logic [mrta_pkg::RADW-1:0]     rem
);

  localparam int RW = mrta_pkg::RADW;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [RW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [RW:0]   shifted;
  logic [RW:0]   trial;
  logic          fits;

  always_comb begin
    shifted  = {r_r, q_r[DW-1]};
    trial    = shifted - {1'b0, d_r};
    fits     = shifted >= {1'b0, d_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], fits};
      r_nxt   = fits ? trial[RW-1:0] : shifted[RW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

`default_nettype wire

### hdl/mixed_radix_timestamp_alu.sv
// Mixed-radix timestamp accumulator (year .. millisecond, seven fields).
// in_ch: valid/ready beat carrying func, the operand timestamp and divisor.
// out_ch: valid/ready beat carrying the accumulator, order, status and flags.
// cfg_we/cfg_idx/cfg_wdata: per-field limits, to be written by the user
// only while the block idles; the block does not enforce this. One item
// is worked at a time; in_ch.ready is high only while idle. Add carries
// and divide go through one restoring divider (one quotient bit a cycle,
// DW = max(max(FIELD_WIDTH,16)+4, 33) bits, 33 at the default width).
// Steps from accept to result beat, by function:
//   load, clear, unused codes, divide by zero: straight to the result
//   compare: one field at a time from year, up to the first difference
//   subtract: one field at a time from millisecond to year, with borrow
//   add: millisecond to year, the divider for each of up to six carries
//   divide: the seven long-division steps, year to millisecond
// Reset (synchronous, rst_n low) clears the accumulator, drops any pending
// result and restores the default limits. When out_ch stalls, the result
// holds in the output register; the next item is still taken and waits in
// its final state until the register frees.
`default_nettype none

module mixed_radix_timestamp_alu #(
  parameter int FIELD_WIDTH = mrta_pkg::FIELD_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  mrta_in_if.sink                           in_ch,
  mrta_out_if.source                        out_ch,
  input  wire                               cfg_we,
  input  wire [mrta_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire [mrta_pkg::OPW-1:0]           cfg_wdata
);

  localparam int W  = FIELD_WIDTH;
  localparam int NF = mrta_pkg::NFIELDS;
  localparam int XW = (W > mrta_pkg::OPW) ? W : mrta_pkg::OPW;
  localparam int AW = XW + 4;
  localparam int DW = (AW > mrta_pkg::PRODW) ? AW : mrta_pkg::PRODW;
  localparam int SW = ((W > mrta_pkg::RADW) ? W : mrta_pkg::RADW) + 2;
  localparam int PW = mrta_pkg::PRODW;
  localparam int RW = mrta_pkg::RADW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_STEP = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  mrta_pkg::fld_t                 fld_r, fld_nxt;
  mrta_pkg::func_code_t           func_r;
  mrta_pkg::word_t                op_r [NF];
  mrta_pkg::word_t                dvr_r;
  mrta_pkg::word_t                lim_r [NF];
  logic [W-1:0]                   acc_r [NF];
  logic [AW-1:0]                  carry_r, carry_nxt;
  logic                           borrow_r, borrow_nxt;
  mrta_pkg::word_t                rest_r, rest_nxt;
  logic [PW-1:0]                  prod_r, prod_nxt;
  logic [DW-1:0]                  cur_r, cur_nxt;
  logic [1:0]                     order_r, order_nxt;
  logic [1:0]                     status_r, status_nxt;

  mrta_pkg::word_t                out_res_r [NF];
  logic [1:0]                     out_order_r;
  logic [1:0]                     out_status_r;
  logic                           out_oor_r;
  logic                           out_empty_r;
  logic                           out_valid_r;

  logic                           acc_we;
  logic [W-1:0]                   acc_wd;
  logic                           acc_load;
  logic                           acc_clear;
  logic                           div_start;
  logic [RW-1:0]                  div_divisor;
  logic                           div_done;
  logic [DW-1:0]                  div_quot;
  logic [RW-1:0]                  div_rem;

  logic [W-1:0]                   acc_f;
  mrta_pkg::word_t                op_f;
  mrta_pkg::word_t                lim_f;
  logic [RW-1:0]                  radix_f;
  logic [RW-1:0]                  sub_v;
  logic [SW-1:0]                  acc_s;
  logic [SW-1:0]                  sub_s;
  logic                           sub_lt;
  logic [SW-1:0]                  diff_wrap;
  logic [SW-1:0]                  diff_plain;
  logic [DW-1:0]                  sum_v;
  logic                           cur_gt;
  logic                           year_ovf;
  logic                           in_acc;
  logic                           out_free;
  logic                           flag_oor;
  logic                           flag_empty;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign acc_f   = acc_r[fld_r];
  assign op_f    = op_r[fld_r];
  assign lim_f   = lim_r[fld_r];
  assign radix_f = RW'(lim_f) + RW'(1);

  assign sub_v      = RW'(op_f) + RW'(borrow_r);
  assign acc_s      = SW'(acc_f);
  assign sub_s      = SW'(sub_v);
  assign sub_lt     = acc_s < sub_s;
  assign diff_wrap  = acc_s + SW'(radix_f) - sub_s;
  assign diff_plain = acc_s - sub_s;

  assign sum_v = (func_r == mrta_pkg::FN_ADD) ?
                 DW'(acc_f) + DW'(op_f) + DW'(carry_r) :
                 DW'(acc_f) + DW'(prod_r);

  assign cur_gt   = cur_r > DW'(lim_f);
  assign year_ovf = (cur_r > DW'(lim_r[mrta_pkg::FLD_YEAR])) || (|cur_r[DW-1:W]);

  assign div_divisor = (func_r == mrta_pkg::FN_ADD) ? radix_f : RW'(dvr_r);

  mrta_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_r),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    fld_nxt    = fld_r;
    carry_nxt  = carry_r;
    borrow_nxt = borrow_r;
    rest_nxt   = rest_r;
    prod_nxt   = prod_r;
    cur_nxt    = cur_r;
    order_nxt  = order_r;
    status_nxt = status_r;
    acc_we     = 1'b0;
    acc_wd     = acc_f;
    acc_load   = 1'b0;
    acc_clear  = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          order_nxt  = mrta_pkg::ORD_LESS;
          status_nxt = mrta_pkg::ST_OK;
          carry_nxt  = '0;
          borrow_nxt = 1'b0;
          rest_nxt   = '0;
          unique case (in_ch.func)
            mrta_pkg::FN_LOAD: begin
              acc_load  = 1'b1;
              state_nxt = S_DONE;
            end
            mrta_pkg::FN_CLEAR: begin
              acc_clear = 1'b1;
              state_nxt = S_DONE;
            end
            mrta_pkg::FN_ADD: begin
              fld_nxt   = mrta_pkg::FLD_MILLI;
              state_nxt = S_SUM;
            end
            mrta_pkg::FN_SUB: begin
              fld_nxt   = mrta_pkg::FLD_MILLI;
              state_nxt = S_STEP;
            end
            mrta_pkg::FN_CMP: begin
              fld_nxt   = mrta_pkg::FLD_YEAR;
              state_nxt = S_STEP;
            end
            mrta_pkg::FN_DIV: begin
              if (in_ch.divisor == '0) begin
                status_nxt = mrta_pkg::ST_DIV_ZERO;
                state_nxt  = S_DONE;
              end else begin
                fld_nxt   = mrta_pkg::FLD_YEAR;
                state_nxt = S_MUL;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_STEP: begin
        if (func_r == mrta_pkg::FN_SUB) begin
          if (fld_r == mrta_pkg::FLD_YEAR) begin
            if (sub_lt) begin
              status_nxt = mrta_pkg::ST_UNDERFLOW;
            end else begin
              acc_we = 1'b1;
              acc_wd = W'(diff_plain);
            end
            state_nxt = S_DONE;
          end else begin
            acc_we     = 1'b1;
            acc_wd     = sub_lt ? W'(diff_wrap) : W'(diff_plain);
            borrow_nxt = sub_lt;
            fld_nxt    = fld_r - mrta_pkg::fld_t'(1);
          end
        end else begin
          if (XW'(acc_f) < XW'(op_f)) begin
            order_nxt = mrta_pkg::ORD_LESS;
            state_nxt = S_DONE;
          end else if (XW'(acc_f) > XW'(op_f)) begin
            order_nxt = mrta_pkg::ORD_GREATER;
            state_nxt = S_DONE;
          end else if (fld_r == mrta_pkg::FLD_MILLI) begin
            order_nxt = mrta_pkg::ORD_EQUAL;
            state_nxt = S_DONE;
          end else begin
            fld_nxt = fld_r + mrta_pkg::fld_t'(1);
          end
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(rest_r) * PW'(radix_f);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cur_nxt   = sum_v;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (func_r == mrta_pkg::FN_ADD) begin
          if (fld_r == mrta_pkg::FLD_YEAR) begin
            acc_we = 1'b1;
            acc_wd = W'(cur_r);
            if (year_ovf) begin
              status_nxt = mrta_pkg::ST_OVERFLOW;
            end
            state_nxt = S_DONE;
          end else if (cur_gt) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            acc_we    = 1'b1;
            acc_wd    = W'(cur_r);
            carry_nxt = '0;
            fld_nxt   = fld_r - mrta_pkg::fld_t'(1);
            state_nxt = S_SUM;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          acc_we = 1'b1;
          if (func_r == mrta_pkg::FN_ADD) begin
            acc_wd    = W'(div_rem);
            carry_nxt = AW'(div_quot);
            fld_nxt   = fld_r - mrta_pkg::fld_t'(1);
            state_nxt = S_SUM;
          end else begin
            acc_wd   = W'(div_quot);
            rest_nxt = mrta_pkg::OPW'(div_rem);
            if (fld_r == mrta_pkg::FLD_MILLI) begin
              state_nxt = S_DONE;
            end else begin
              fld_nxt   = fld_r + mrta_pkg::fld_t'(1);
              state_nxt = S_MUL;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    flag_oor   = 1'b0;
    flag_empty = 1'b1;
    for (int i = 0; i < NF; i++) begin
      if (XW'(acc_r[i]) > XW'(lim_r[i])) begin
        flag_oor = 1'b1;
      end
      if (acc_r[i] != '0) begin
        flag_empty = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        acc_r[i] <= '0;
        lim_r[i] <= mrta_pkg::LIM_RST[i];
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we && cfg_idx <= mrta_pkg::CFG_YEAR_LIMIT) begin
        lim_r[mrta_pkg::cfg_field(cfg_idx)] <= cfg_wdata;
      end
      if (acc_load) begin
        acc_r[mrta_pkg::FLD_YEAR]   <= W'(in_ch.op_year);
        acc_r[mrta_pkg::FLD_MONTH]  <= W'(in_ch.op_month);
        acc_r[mrta_pkg::FLD_DAY]    <= W'(in_ch.op_day);
        acc_r[mrta_pkg::FLD_HOUR]   <= W'(in_ch.op_hour);
        acc_r[mrta_pkg::FLD_MINUTE] <= W'(in_ch.op_minute);
        acc_r[mrta_pkg::FLD_SECOND] <= W'(in_ch.op_second);
        acc_r[mrta_pkg::FLD_MILLI]  <= W'(in_ch.op_milli);
      end else if (acc_clear) begin
        for (int i = 0; i < NF; i++) begin
          acc_r[i] <= '0;
        end
      end else if (acc_we) begin
        acc_r[fld_r] <= acc_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    fld_r    <= fld_nxt;
    carry_r  <= carry_nxt;
    borrow_r <= borrow_nxt;
    rest_r   <= rest_nxt;
    prod_r   <= prod_nxt;
    cur_r    <= cur_nxt;
    order_r  <= order_nxt;
    status_r <= status_nxt;
    if (in_acc) begin
      func_r                      <= in_ch.func;
      dvr_r                       <= in_ch.divisor;
      op_r[mrta_pkg::FLD_YEAR]    <= in_ch.op_year;
      op_r[mrta_pkg::FLD_MONTH]   <= in_ch.op_month;
      op_r[mrta_pkg::FLD_DAY]     <= in_ch.op_day;
      op_r[mrta_pkg::FLD_HOUR]    <= in_ch.op_hour;
      op_r[mrta_pkg::FLD_MINUTE]  <= in_ch.op_minute;
      op_r[mrta_pkg::FLD_SECOND]  <= in_ch.op_second;
      op_r[mrta_pkg::FLD_MILLI]   <= in_ch.op_milli;
    end
    if (state_r == S_DONE && out_free) begin
      for (int i = 0; i < NF; i++) begin
        out_res_r[i] <= mrta_pkg::OPW'(acc_r[i]);
      end
      out_order_r  <= order_r;
      out_status_r <= status_r;
      out_oor_r    <= flag_oor;
      out_empty_r  <= flag_empty;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.res_year     = out_res_r[mrta_pkg::FLD_YEAR];
  assign out_ch.res_month    = out_res_r[mrta_pkg::FLD_MONTH];
  assign out_ch.res_day      = out_res_r[mrta_pkg::FLD_DAY];
  assign out_ch.res_hour     = out_res_r[mrta_pkg::FLD_HOUR];
  assign out_ch.res_minute   = out_res_r[mrta_pkg::FLD_MINUTE];
  assign out_ch.res_second   = out_res_r[mrta_pkg::FLD_SECOND];
  assign out_ch.res_milli    = out_res_r[mrta_pkg::FLD_MILLI];
  assign out_ch.order        = out_order_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_of_range = out_oor_r;
  assign out_ch.is_empty     = out_empty_r;

endmodule

`default_nettype wire

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrta_pkg::*;

  localparam func_code_t FN_SPARE6 = 3'd6;
  localparam func_code_t FN_SPARE7 = 3'd7;

  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 266;
  localparam int SQUEEZE_AT     = 200;
  localparam int SQUEEZE_CYCLES = 1000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int REPORT_LIMIT   = 10;

  typedef word_t [0:NFIELDS-1] stamp_t;

  typedef struct packed {
    func_code_t func;
    stamp_t     op;
    word_t      divisor;
  } op_item_t;

  typedef struct packed {
    stamp_t     acc;
    logic [1:0] order;
    logic [1:0] status;
    logic       oor;
    logic       empty;
  } acc_report_t;

  typedef struct packed {
    op_item_t    item;
    logic        typed;
    acc_report_t want;
  } row_t;

  localparam cfg_idx_t CFG_OF_FIELD [NFIELDS] = '{
    CFG_YEAR_LIMIT, CFG_MONTH_LIMIT, CFG_DAY_LIMIT, CFG_HOUR_LIMIT,
    CFG_MINUTE_LIMIT, CFG_SECOND_LIMIT, CFG_MILLI_LIMIT
  };

  localparam stamp_t CALENDAR_LIMITS = '{
    16'd4095, 16'd11, 16'd30, 16'd23, 16'd59, 16'd59, 16'd999
  };
  localparam stamp_t STAMP_ZERO    = '0;
  localparam stamp_t STAMP_MAX     = '1;
  localparam stamp_t ONE_MILLI     = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
  localparam stamp_t CALENDAR_LATE = '{
    16'd2024, 16'd11, 16'd30, 16'd23, 16'd59, 16'd59, 16'd999
  };
  localparam stamp_t CALENDAR_TOP  = '{
    16'd4095, 16'd11, 16'd30, 16'd23, 16'd59, 16'd59, 16'd999
  };
  localparam stamp_t MID_STAMP     = '{
    16'd100, 16'd5, 16'd10, 16'd12, 16'd30, 16'd30, 16'd500
  };

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  word_t    cfg_wdata;

  mrta_in_if  in_ch ();
  mrta_out_if out_ch ();

  mixed_radix_timestamp_alu u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  stamp_t      acc_model;
  stamp_t      lim_model;
  acc_report_t pending_reports [$];
  row_t        directed_rows [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  bit          squeezed     = 1'b0;
  string       field_label [NFIELDS] = '{
    "year", "month", "day", "hour", "minute", "second", "milli"
  };

  function automatic acc_report_t timestamp_step(op_item_t it);
    logic [63:0] a [NFIELDS];
    logic [63:0] o [NFIELDS];
    logic [63:0] radix;
    logic [63:0] carry;
    logic [63:0] sub;
    logic [63:0] v;
    logic [63:0] rest;
    acc_report_t r;
    r = '0;
    r.order  = ORD_LESS;
    r.status = ST_OK;
    r.empty  = 1'b1;
    for (int f = 0; f < NFIELDS; f++) begin
      a[f] = acc_model[f];
      o[f] = it.op[f];
    end
    case (it.func)
      FN_LOAD: begin
        for (int f = 0; f < NFIELDS; f++) a[f] = o[f];
      end
      FN_ADD: begin
        for (int f = 0; f < NFIELDS; f++) a[f] = a[f] + o[f];
        for (int f = NFIELDS - 1; f >= 1; f--) begin
          radix = 64'(lim_model[f]) + 64'd1;
          if (a[f] > lim_model[f]) begin
            a[f-1] = a[f-1] + a[f] / radix;
            a[f]   = a[f] % radix;
          end
        end
        if (a[0] > lim_model[0] || a[0] > 64'hFFFF) r.status = ST_OVERFLOW;
      end
      FN_SUB: begin
        carry = 0;
        for (int f = NFIELDS - 1; f >= 1; f--) begin
          sub = o[f] + carry;
          if (a[f] < sub) begin
            a[f]  = a[f] + 64'(lim_model[f]) + 64'd1 - sub;
            carry = 1;
          end else begin
            a[f]  = a[f] - sub;
            carry = 0;
          end
        end
        sub = o[0] + carry;
        if (a[0] < sub) r.status = ST_UNDERFLOW;
        else a[0] = a[0] - sub;
      end
      FN_CMP: begin
        r.order = ORD_EQUAL;
        for (int f = 0; f < NFIELDS; f++) begin
          if (a[f] < o[f]) begin
            r.order = ORD_LESS;
            break;
          end
          if (a[f] > o[f]) begin
            r.order = ORD_GREATER;
            break;
          end
        end
      end
      FN_DIV: begin
        if (it.divisor == '0) begin
          r.status = ST_DIV_ZERO;
        end else begin
          rest = 0;
          for (int f = 0; f < NFIELDS; f++) begin
            v    = a[f] + rest * (64'(lim_model[f]) + 64'd1);
            rest = v % it.divisor;
            a[f] = v / it.divisor;
          end
        end
      end
      FN_CLEAR: begin
        for (int f = 0; f < NFIELDS; f++) a[f] = 0;
      end
      default: ;
    endcase
    for (int f = 0; f < NFIELDS; f++) begin
      acc_model[f] = a[f][15:0];
      r.acc[f]     = acc_model[f];
      if (acc_model[f] > lim_model[f]) r.oor = 1'b1;
      if (acc_model[f] != '0) r.empty = 1'b0;
    end
    return r;
  endfunction

  function automatic word_t draw_field(int f);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return word_t'($urandom_range(lim_model[f], 0));
    if (r < 80) return lim_model[f];
    if (r < 85) return '0;
    return word_t'($urandom);
  endfunction

  function automatic op_item_t compose_item();
    op_item_t    it;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99, 0);
    if (r < 14)      it.func = FN_LOAD;
    else if (r < 38) it.func = FN_ADD;
    else if (r < 60) it.func = FN_SUB;
    else if (r < 74) it.func = FN_CMP;
    else if (r < 90) it.func = FN_DIV;
    else if (r < 95) it.func = FN_CLEAR;
    else if (r < 98) it.func = FN_SPARE6;
    else             it.func = FN_SPARE7;
    for (int f = 0; f < NFIELDS; f++) it.op[f] = draw_field(f);
    if ((it.func == FN_ADD || it.func == FN_SUB) && $urandom_range(99, 0) < 60)
      it.op[FLD_YEAR] = word_t'($urandom_range(4, 0));
    if (it.func == FN_CMP) begin
      r = $urandom_range(99, 0);
      if (r < 55) it.op = acc_model;
      if (r >= 30 && r < 55) begin
        k = $urandom_range(NFIELDS - 1, 0);
        it.op[k] = it.op[k] + ($urandom_range(1, 0) ? 16'd1 : 16'hFFFF);
      end
    end
    r = $urandom_range(99, 0);
    if (r < 8)       it.divisor = '0;
    else if (r < 48) it.divisor = word_t'($urandom_range(10, 1));
    else if (r < 70) it.divisor = lim_model[$urandom_range(NFIELDS - 1, 1)] + 16'd1;
    else             it.divisor = word_t'($urandom);
    return it;
  endfunction

  function automatic row_t step_row(func_code_t fn, stamp_t op, word_t dv);
    row_t r;
    r = '0;
    r.item.func    = fn;
    r.item.op      = op;
    r.item.divisor = dv;
    return r;
  endfunction

  function automatic row_t known_row(func_code_t fn, stamp_t op, word_t dv, stamp_t acc,
                                     logic [1:0] ord, logic [1:0] st, logic oor, logic empty);
    row_t r;
    r = step_row(fn, op, dv);
    r.typed = 1'b1;
    r.want  = '{acc, ord, st, oor, empty};
    return r;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if ((items_sent / 100) % 3 == 0) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(20, 4);
    return $urandom_range(200, 50);
  endfunction

  task automatic offer_item(op_item_t it, logic typed, acc_report_t want);
    int unsigned gap;
    acc_report_t predicted;
    gap = sender_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= it.func;
    in_ch.op_year   <= it.op[FLD_YEAR];
    in_ch.op_month  <= it.op[FLD_MONTH];
    in_ch.op_day    <= it.op[FLD_DAY];
    in_ch.op_hour   <= it.op[FLD_HOUR];
    in_ch.op_minute <= it.op[FLD_MINUTE];
    in_ch.op_second <= it.op[FLD_SECOND];
    in_ch.op_milli  <= it.op[FLD_MILLI];
    in_ch.divisor   <= it.divisor;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = timestamp_step(it);
    pending_reports.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic program_limits(stamp_t lims);
    while (pending_reports.size() != 0) @(posedge clk);
    for (int f = 0; f < NFIELDS; f++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_OF_FIELD[f];
      cfg_wdata <= lims[f];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    lim_model = lims;
  endtask

  task automatic check_field(int unsigned beat, string what, logic [15:0] want_v,
                             logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("beat %0d %s: expected %0d, got %0d", beat, what, want_v, got_v);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    acc_report_t got;
    acc_report_t want;
    int unsigned stall_left;
    int unsigned rx_cycles;
    int unsigned r;
    stall_left   = 0;
    rx_cycles    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.acc[FLD_YEAR]   = out_ch.res_year;
        got.acc[FLD_MONTH]  = out_ch.res_month;
        got.acc[FLD_DAY]    = out_ch.res_day;
        got.acc[FLD_HOUR]   = out_ch.res_hour;
        got.acc[FLD_MINUTE] = out_ch.res_minute;
        got.acc[FLD_SECOND] = out_ch.res_second;
        got.acc[FLD_MILLI]  = out_ch.res_milli;
        got.order  = out_ch.order;
        got.status = out_ch.status;
        got.oor    = out_ch.out_of_range;
        got.empty  = out_ch.is_empty;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("beat %0d: result beat with nothing pending", results_seen);
        end else begin
          want = pending_reports.pop_front();
          for (int f = 0; f < NFIELDS; f++)
            check_field(results_seen, field_label[f], want.acc[f], got.acc[f]);
          check_field(results_seen, "order", want.order, got.order);
          check_field(results_seen, "status", want.status, got.status);
          check_field(results_seen, "out_of_range", want.oor, got.oor);
          check_field(results_seen, "is_empty", want.empty, got.empty);
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!squeezed && results_seen >= SQUEEZE_AT) begin
        squeezed     = 1'b1;
        stall_left   = SQUEEZE_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if ((rx_cycles / 512) % 3 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 75) begin
          out_ch.ready <= 1'b1;
        end else begin
          stall_left   = (r < 95) ? $urandom_range(3, 0) : $urandom_range(199, 19);
          out_ch.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    stamp_t next_limits;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_MILLI_LIMIT;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FN_LOAD;
    in_ch.op_year   <= '0;
    in_ch.op_month  <= '0;
    in_ch.op_day    <= '0;
    in_ch.op_hour   <= '0;
    in_ch.op_minute <= '0;
    in_ch.op_second <= '0;
    in_ch.op_milli  <= '0;
    in_ch.divisor   <= '0;
    acc_model = '0;
    lim_model = CALENDAR_LIMITS;

    directed_rows.push_back(known_row(FN_CMP, STAMP_ZERO, 16'd0,
                                      STAMP_ZERO, ORD_EQUAL, ST_OK, 1'b0, 1'b1));
    directed_rows.push_back(known_row(FN_LOAD, STAMP_MAX, 16'd0,
                                      STAMP_MAX, ORD_LESS, ST_OK, 1'b1, 1'b0));
    directed_rows.push_back(known_row(FN_DIV, STAMP_ZERO, 16'd0,
                                      STAMP_MAX, ORD_LESS, ST_DIV_ZERO, 1'b1, 1'b0));
    directed_rows.push_back(known_row(FN_CMP, STAMP_MAX, 16'd0,
                                      STAMP_MAX, ORD_EQUAL, ST_OK, 1'b1, 1'b0));
    directed_rows.push_back(known_row(FN_CMP, STAMP_ZERO, 16'd0,
                                      STAMP_MAX, ORD_GREATER, ST_OK, 1'b1, 1'b0));
    directed_rows.push_back(known_row(FN_SPARE6, STAMP_ZERO, 16'hFFFF,
                                      STAMP_MAX, ORD_LESS, ST_OK, 1'b1, 1'b0));
    directed_rows.push_back(known_row(FN_SPARE7, STAMP_MAX, 16'd0,
                                      STAMP_MAX, ORD_LESS, ST_OK, 1'b1, 1'b0));
    directed_rows.push_back(step_row(FN_ADD, STAMP_MAX, 16'd0));
    directed_rows.push_back(step_row(FN_DIV, STAMP_ZERO, 16'hFFFF));
    directed_rows.push_back(known_row(FN_CLEAR, STAMP_MAX, 16'd0,
                                      STAMP_ZERO, ORD_LESS, ST_OK, 1'b0, 1'b1));
    directed_rows.push_back(step_row(FN_SUB, ONE_MILLI, 16'd0));
    directed_rows.push_back(known_row(FN_CLEAR, STAMP_ZERO, 16'd0,
                                      STAMP_ZERO, ORD_LESS, ST_OK, 1'b0, 1'b1));
    directed_rows.push_back(known_row(FN_LOAD, CALENDAR_LATE, 16'd0,
                                      CALENDAR_LATE, ORD_LESS, ST_OK, 1'b0, 1'b0));
    directed_rows.push_back(step_row(FN_ADD, ONE_MILLI, 16'd0));
    directed_rows.push_back(known_row(FN_LOAD, CALENDAR_TOP, 16'd0,
                                      CALENDAR_TOP, ORD_LESS, ST_OK, 1'b0, 1'b0));
    directed_rows.push_back(step_row(FN_ADD, ONE_MILLI, 16'd0));
    directed_rows.push_back(step_row(FN_SUB, STAMP_MAX, 16'd0));
    directed_rows.push_back(known_row(FN_LOAD, MID_STAMP, 16'd0,
                                      MID_STAMP, ORD_LESS, ST_OK, 1'b0, 1'b0));
    directed_rows.push_back(step_row(FN_DIV, STAMP_ZERO, 16'd7));
    directed_rows.push_back(step_row(FN_CMP, MID_STAMP, 16'd0));
    directed_rows.push_back(step_row(FN_DIV, STAMP_ZERO, 16'd1));
    directed_rows.push_back(step_row(FN_DIV, STAMP_ZERO, 16'hFFFF));
    directed_rows.push_back(known_row(FN_LOAD, STAMP_ZERO, 16'd0,
                                      STAMP_ZERO, ORD_LESS, ST_OK, 1'b0, 1'b1));
    directed_rows.push_back(step_row(FN_SUB, STAMP_ZERO, 16'd0));
    directed_rows.push_back(step_row(FN_ADD, STAMP_MAX, 16'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        case (p)
          1: next_limits = '{16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
          2: next_limits = '{16'hFFFF, 16'd65534, 16'd65534, 16'd65534,
                             16'd65534, 16'd65534, 16'd65534};
          3: begin
            next_limits[FLD_YEAR] = word_t'($urandom_range(65535, 0));
            for (int f = 1; f < NFIELDS; f++)
              next_limits[f] = $urandom_range(1, 0) ? word_t'($urandom_range(100, 1))
                                                    : word_t'($urandom_range(65534, 1));
          end
          default: next_limits = CALENDAR_LIMITS;
        endcase
        in_ch.valid <= 1'b0;
        program_limits(next_limits);
      end
      repeat (PHASE_ITEMS) offer_item(compose_item(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
